// ----- src/qgemm_pkg.sv -----
// Shared types and constants for the quantized GEMM dot-product accumulator.
// No dependencies; used by every module of the block.
package qgemm_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ZP_W    = 9;
	localparam int unsigned MAX_LANES = 4;
	localparam int unsigned ADDR_W  = 3;

	typedef enum logic {
		REG_ZERO_MODE  = 1'b0,
		REG_PER_COL_ZP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic zero_mode;
		logic per_column_zero_point;
	} cfg_t;

	// Stage 2 terms handed to the accumulator.
	typedef struct packed {
		logic              first_group;
		logic              last_group;
		logic [DATA_W-1:0] seed;
		logic [DATA_W-1:0] prod_sum;
		logic [DATA_W-1:0] prior_add;
	} terms_t;

endpackage

// ----- src/quantized_gemm_dot_accumulate.sv -----
// Quantized 8-bit GEMM dot-product accumulator, one int32 element per run.
// Path from accepted word to c_value: input reg, term reg, output reg.
// Throughput: one word per cycle; the three-stage pipeline holds as a whole
// only while a finished result waits under out_stall.
// Reset clears valid bits, the accumulator, and sets zero_mode=1, per-column zp=0.
// Depends on qgemm_pkg, qgemm_cfg, qgemm_prep.
module quantized_gemm_dot_accumulate #(
	parameter int unsigned LANES = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic        [qgemm_pkg::ADDR_W-1:0]   paddr,
	input  logic        [qgemm_pkg::DATA_W-1:0]   pwdata,
	output logic        [qgemm_pkg::DATA_W-1:0]   prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic        [qgemm_pkg::DATA_W-1:0]   a_bytes,
	input  logic        [qgemm_pkg::DATA_W-1:0]   b_bytes,
	input  logic                                  first_group,
	input  logic                                  last_group,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   row_sum,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   column_sum,
	input  logic signed [qgemm_pkg::ZP_W-1:0]     zero_point_b,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   prior_c,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [qgemm_pkg::DATA_W-1:0]   c_value
);

	qgemm_pkg::cfg_t   cfg;
	qgemm_pkg::terms_t terms_s2;

	logic adv;
	logic v_s1, v_s2;
	logic out_valid_q;
	logic [qgemm_pkg::DATA_W-1:0] acc_q, acc_next, c_value_q;

	logic        [qgemm_pkg::DATA_W-1:0] a_bytes_s1, b_bytes_s1;
	logic                                first_s1, last_s1;
	logic signed [qgemm_pkg::DATA_W-1:0] row_sum_s1, column_sum_s1, prior_c_s1;
	logic signed [qgemm_pkg::ZP_W-1:0]   zero_point_b_s1;

	qgemm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline moves unless a result is waiting and stalled
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			a_bytes_s1      <= a_bytes;
			b_bytes_s1      <= b_bytes;
			first_s1        <= first_group;
			last_s1         <= last_group;
			row_sum_s1      <= row_sum;
			column_sum_s1   <= column_sum;
			zero_point_b_s1 <= zero_point_b;
			prior_c_s1      <= prior_c;
		end
	end

	qgemm_prep #(
		.LANES (LANES)
	) u_prep (
		.clk          (clk),
		.en           (adv && v_s1),
		.cfg          (cfg),
		.a_bytes      (a_bytes_s1),
		.b_bytes      (b_bytes_s1),
		.first_group  (first_s1),
		.last_group   (last_s1),
		.row_sum      (row_sum_s1),
		.column_sum   (column_sum_s1),
		.zero_point_b (zero_point_b_s1),
		.prior_c      (prior_c_s1),
		.terms_s2     (terms_s2)
	);

	assign acc_next = (terms_s2.first_group ? terms_s2.seed : acc_q)
	                + terms_s2.prod_sum + terms_s2.prior_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (v_s2) begin
				acc_q <= acc_next;
			end
			out_valid_q <= v_s2 && terms_s2.last_group;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && terms_s2.last_group) begin
			c_value_q <= acc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign c_value   = c_value_q;

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && v_s2) |=> $stable(acc_q))
		else $error("accumulator changed without an advancing word");

	a_result_matches_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && terms_s2.last_group) |=> (out_valid && c_value == acc_q))
		else $error("emitted result differs from accumulator");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while result is stalled");

endmodule

// ----- src/qgemm_cfg.sv -----
// APB-style configuration registers: zero_mode and per_column_zero_point.
// Depends on qgemm_pkg.
module qgemm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qgemm_pkg::ADDR_W-1:0]  paddr,
	input  logic [qgemm_pkg::DATA_W-1:0]  pwdata,
	output logic [qgemm_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output qgemm_pkg::cfg_t               cfg
);

	qgemm_pkg::cfg_t   cfg_q;
	qgemm_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = qgemm_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_mode             <= 1'b1;
			cfg_q.per_column_zero_point <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				qgemm_pkg::REG_ZERO_MODE:  cfg_q.zero_mode             <= pwdata[0];
				qgemm_pkg::REG_PER_COL_ZP: cfg_q.per_column_zero_point <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			qgemm_pkg::REG_ZERO_MODE:  prdata[0] = cfg_q.zero_mode;
			qgemm_pkg::REG_PER_COL_ZP: prdata[0] = cfg_q.per_column_zero_point;
			default: prdata = '0;
		endcase
	end

endmodule

// ----- src/qgemm_prep.sv -----
// Stage 2: byte-lane products, seed (row_sum, times zero point in per-column
// mode, + column_sum) and prior_c term, registered. Depends on qgemm_pkg.
module qgemm_prep #(
	parameter int unsigned LANES = 4
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  qgemm_pkg::cfg_t                       cfg,
	input  logic        [qgemm_pkg::DATA_W-1:0]   a_bytes,
	input  logic        [qgemm_pkg::DATA_W-1:0]   b_bytes,
	input  logic                                  first_group,
	input  logic                                  last_group,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   row_sum,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   column_sum,
	input  logic signed [qgemm_pkg::ZP_W-1:0]     zero_point_b,
	input  logic signed [qgemm_pkg::DATA_W-1:0]   prior_c,
	output qgemm_pkg::terms_t                     terms_s2
);

	localparam int unsigned ACT   = (LANES < qgemm_pkg::MAX_LANES) ? LANES
	                                : qgemm_pkg::MAX_LANES;
	localparam int unsigned SUM_W = 2 * qgemm_pkg::BYTE_W + $clog2(ACT);
	localparam int unsigned MUL_W = qgemm_pkg::DATA_W + qgemm_pkg::ZP_W;

	logic        [SUM_W-1:0]              psum;
	logic signed [MUL_W-1:0]              zp_prod;
	logic        [qgemm_pkg::DATA_W-1:0]  row_term;
	qgemm_pkg::terms_t                    terms;

	always_comb begin
		psum = '0;
		for (int i = 0; i < ACT; i++) begin
			psum = psum + SUM_W'(a_bytes[qgemm_pkg::BYTE_W*i +: qgemm_pkg::BYTE_W])
			            * SUM_W'(b_bytes[qgemm_pkg::BYTE_W*i +: qgemm_pkg::BYTE_W]);
		end
	end

	assign zp_prod  = row_sum * zero_point_b;
	assign row_term = cfg.per_column_zero_point ? zp_prod[qgemm_pkg::DATA_W-1:0]
	                                            : row_sum;

	always_comb begin
		terms.first_group = first_group;
		terms.last_group  = last_group;
		terms.seed        = row_term + column_sum;
		terms.prod_sum    = qgemm_pkg::DATA_W'(psum);
		terms.prior_add   = (last_group && !cfg.zero_mode) ? prior_c : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s2 <= terms;
		end
	end

endmodule

// ----- sim/quantized_gemm_dot_accumulate_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for quantized_gemm_dot_accumulate: directed and random word runs,
// APB register setup, random idling on both handshakes. Depends on qgemm_pkg and the RTL only.
module quantized_gemm_dot_accumulate_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [qgemm_pkg::DATA_W-1:0] a;
		logic [qgemm_pkg::DATA_W-1:0] b;
		logic                         is_first;
		logic                         is_last;
		logic [qgemm_pkg::DATA_W-1:0] row;
		logic [qgemm_pkg::DATA_W-1:0] col;
		logic [qgemm_pkg::ZP_W-1:0]   zp;
		logic [qgemm_pkg::DATA_W-1:0] prior;
	} gemm_word_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 psel;
	logic                                 penable;
	logic                                 pwrite;
	logic        [qgemm_pkg::ADDR_W-1:0]  paddr;
	logic        [qgemm_pkg::DATA_W-1:0]  pwdata;
	logic        [qgemm_pkg::DATA_W-1:0]  prdata;
	logic                                 pready;
	logic                                 in_valid;
	logic                                 in_stall;
	logic        [qgemm_pkg::DATA_W-1:0]  a_bytes;
	logic        [qgemm_pkg::DATA_W-1:0]  b_bytes;
	logic                                 first_group;
	logic                                 last_group;
	logic signed [qgemm_pkg::DATA_W-1:0]  row_sum;
	logic signed [qgemm_pkg::DATA_W-1:0]  column_sum;
	logic signed [qgemm_pkg::ZP_W-1:0]    zero_point_b;
	logic signed [qgemm_pkg::DATA_W-1:0]  prior_c;
	logic                                 out_valid;
	logic                                 out_stall;
	logic signed [qgemm_pkg::DATA_W-1:0]  c_value;

	// predictor state
	logic [qgemm_pkg::DATA_W-1:0] acc_model;
	logic                         cfg_zero_mode;
	logic                         cfg_per_col_zp;
	logic [qgemm_pkg::DATA_W-1:0] c_pending[$];
	logic [qgemm_pkg::DATA_W-1:0] c_expected;

	int send_idle_pct;
	int stall_pct;
	int mismatches;
	int words_sent;
	int results_checked;
	int config_writes;
	int quiet_cycles;

	quantized_gemm_dot_accumulate #(
		.LANES(4)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_bytes(a_bytes),
		.b_bytes(b_bytes),
		.first_group(first_group),
		.last_group(last_group),
		.row_sum(row_sum),
		.column_sum(column_sum),
		.zero_point_b(zero_point_b),
		.prior_c(prior_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.c_value(c_value)
	);

	always #1 clk = ~clk;

	task automatic note_mismatch(input string what, input logic [qgemm_pkg::DATA_W-1:0] want,
			input logic [qgemm_pkg::DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	function automatic logic [qgemm_pkg::DATA_W-1:0] byte_dot(
			input logic [qgemm_pkg::DATA_W-1:0] a, input logic [qgemm_pkg::DATA_W-1:0] b);
		logic [qgemm_pkg::DATA_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < qgemm_pkg::MAX_LANES; i++) begin
			sum += qgemm_pkg::DATA_W'(a[qgemm_pkg::BYTE_W*i +: qgemm_pkg::BYTE_W])
			     * qgemm_pkg::DATA_W'(b[qgemm_pkg::BYTE_W*i +: qgemm_pkg::BYTE_W]);
		end
		return sum;
	endfunction

	task automatic accumulate_word(input gemm_word_t w);
		logic [qgemm_pkg::DATA_W-1:0] seed;
		if (w.is_first) begin
			seed = w.row;
			if (cfg_per_col_zp) begin
				seed = seed * {{(qgemm_pkg::DATA_W-qgemm_pkg::ZP_W){w.zp[qgemm_pkg::ZP_W-1]}},
					w.zp};
			end
			acc_model = seed + w.col;
		end
		acc_model += byte_dot(w.a, w.b);
		if (w.is_last) begin
			if (!cfg_zero_mode) begin
				acc_model += w.prior;
			end
			c_pending.push_back(acc_model);
		end
	endtask

	function automatic logic [qgemm_pkg::DATA_W-1:0] rand_wide();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [qgemm_pkg::DATA_W-1:0] rand_bytes();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [qgemm_pkg::ZP_W-1:0] rand_zp();
		case ($urandom_range(7))
			0: return 9'h100;
			1: return 9'h0ff;
			2: return 9'h101;
			default: return qgemm_pkg::ZP_W'($urandom);
		endcase
	endfunction

	function automatic gemm_word_t make_word(input logic [qgemm_pkg::DATA_W-1:0] a,
			input logic [qgemm_pkg::DATA_W-1:0] b, input logic f, input logic l,
			input logic [qgemm_pkg::DATA_W-1:0] row, input logic [qgemm_pkg::DATA_W-1:0] col,
			input logic [qgemm_pkg::ZP_W-1:0] zp, input logic [qgemm_pkg::DATA_W-1:0] prior);
		gemm_word_t w;
		w.a = a;
		w.b = b;
		w.is_first = f;
		w.is_last = l;
		w.row = row;
		w.col = col;
		w.zp = zp;
		w.prior = prior;
		return w;
	endfunction

	function automatic gemm_word_t rand_word(input logic f, input logic l);
		return make_word(rand_bytes(), rand_bytes(), f, l, rand_wide(), rand_wide(), rand_zp(),
			rand_wide());
	endfunction

	task automatic send_word(input gemm_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			a_bytes <= $urandom;
			first_group <= 1'($urandom);
			last_group <= 1'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_bytes <= w.a;
		b_bytes <= w.b;
		first_group <= w.is_first;
		last_group <= w.is_last;
		row_sum <= w.row;
		column_sum <= w.col;
		zero_point_b <= w.zp;
		prior_c <= w.prior;
		do @(posedge clk); while (in_stall);
		accumulate_word(w);
		words_sent++;
	endtask

	task automatic wait_drain(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (c_pending.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_write(input qgemm_pkg::reg_idx_t idx, input logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= qgemm_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			qgemm_pkg::REG_ZERO_MODE:  cfg_zero_mode = value;
			qgemm_pkg::REG_PER_COL_ZP: cfg_per_col_zp = value;
		endcase
		config_writes++;
		@(posedge clk);
	endtask

	task automatic check_register(input qgemm_pkg::reg_idx_t idx, input logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== qgemm_pkg::DATA_W'(value)) begin
			note_mismatch(idx.name(), qgemm_pkg::DATA_W'(value), prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic zm, input logic pcz);
		wait_drain(DRAIN_CYCLES);
		apb_write(qgemm_pkg::REG_ZERO_MODE, zm);
		apb_write(qgemm_pkg::REG_PER_COL_ZP, pcz);
		check_register(qgemm_pkg::REG_ZERO_MODE, zm);
		check_register(qgemm_pkg::REG_PER_COL_ZP, pcz);
	endtask

	task automatic test_reset_values();
		check_register(qgemm_pkg::REG_ZERO_MODE, 1'b1);
		check_register(qgemm_pkg::REG_PER_COL_ZP, 1'b0);
	endtask

	// default registers: continuation from reset, a single-word run, wrap, continuation after result
	task automatic test_run_boundaries();
		send_word(make_word(32'h0102_0304, 32'h0506_0708, 0, 1, 32'h1111_1111, 32'h2222_2222,
			9'h055, 32'h7fff_ffff));
		send_word(make_word('1, '1, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 9'h1ff, 32'h0));
		send_word(make_word('0, '1, 0, 0, 32'h0, 32'h0, 9'h000, 32'h8000_0000));
		send_word(make_word('1, '1, 0, 1, '1, '1, 9'h0aa, '1));
		send_word(make_word(32'hdead_beef, 32'h1234_5678, 1, 0, 32'h8000_0000, 32'h8000_0000,
			9'h100, 32'h0));
		send_word(make_word(32'hff00_00ff, 32'h00ff_ff00, 0, 0, '1, '1, 9'h0ff, '1));
		send_word(make_word(32'h8080_8080, 32'h7f7f_7f7f, 0, 1, 32'h0, 32'h0, 9'h000,
			32'h1234_5678));
	endtask

	task automatic test_zero_point_extremes();
		set_config(1'b0, 1'b1);
		send_word(make_word(32'h0102_0304, 32'hff00_ff00, 1, 1, 32'h0000_0001, 32'h0, 9'h100,
			32'h7fff_ffff));
		send_word(make_word('1, '1, 1, 1, '1, 32'h7fff_ffff, 9'h0ff, 32'h8000_0000));
		send_word(make_word(32'h8080_8080, 32'h0101_0101, 1, 0, 32'h8000_0000, 32'h8000_0000,
			9'h101, 32'h0));
		send_word(make_word('0, '0, 0, 1, 32'h1234_5678, 32'h0, 9'h000, '1));
		send_word(make_word(32'h00ff_00ff, 32'hff00_ff00, 1, 1, 32'h7fff_ffff, 32'h0000_0001,
			9'h001, '1));
	endtask

	task automatic test_mode_extremes();
		set_config(1'b0, 1'b0);
		send_word(make_word('1, '1, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 9'h100, '1));
		send_word(make_word(32'h0000_00ff, 32'h0000_00ff, 1, 1, '0, '0, 9'h0ff, 32'h8000_0000));
		set_config(1'b1, 1'b1);
		send_word(make_word('1, '1, 1, 1, 32'h8000_0000, '1, 9'h100, 32'h7fff_ffff));
		send_word(make_word(32'h0f0f_0f0f, 32'hf0f0_f0f0, 1, 1, '1, 32'h0, 9'h1ff, '1));
	endtask

	// mostly well-formed runs; about one draw in eight sends a lone word with random first/last marks
	task automatic test_random_traffic(input int n_words, input logic zm, input logic pcz,
			input int pause_every);
		int count;
		int len;
		int next_pause;
		count = 0;
		next_pause = pause_every;
		set_config(zm, pcz);
		while (count < n_words) begin
			if (pause_every != 0 && count >= next_pause) begin
				wait_drain(0);
				next_pause += pause_every;
			end
			if ($urandom_range(7) == 0) begin
				send_word(rand_word(1'($urandom), 1'($urandom)));
				count++;
			end else begin
				len = $urandom_range(1, 6);
				if (len > n_words - count) len = n_words - count;
				for (int k = 0; k < len; k++) begin
					send_word(rand_word(k == 0, k == len - 1));
				end
				count += len;
			end
		end
	endtask

	task automatic test_pause_until_drained();
		test_random_traffic(75, 1'b1, 1'b0, 20);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (c_pending.size() == 0) begin
				note_mismatch("c_value with nothing pending", 'x, c_value);
			end else begin
				c_expected = c_pending.pop_front();
				if (c_value !== c_expected) begin
					note_mismatch("c_value", c_expected, c_value);
				end
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		a_bytes = '0;
		b_bytes = '0;
		first_group = 1'b0;
		last_group = 1'b0;
		row_sum = '0;
		column_sum = '0;
		zero_point_b = '0;
		prior_c = '0;
		out_stall = 1'b0;
		acc_model = '0;
		cfg_zero_mode = 1'b1;
		cfg_per_col_zp = 1'b0;
		mismatches = 0;
		words_sent = 0;
		results_checked = 0;
		config_writes = 0;
		quiet_cycles = 0;
		send_idle_pct = 13;
		stall_pct = 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_run_boundaries();
		test_zero_point_extremes();
		test_mode_extremes();

		test_random_traffic(75, 1'b1, 1'b0, 0);
		test_random_traffic(75, 1'b0, 1'b1, 0);
		send_idle_pct = 55;
		stall_pct = 13;
		test_random_traffic(75, 1'b0, 1'b0, 0);
		test_random_traffic(75, 1'b1, 1'b1, 0);
		send_idle_pct = 0;
		stall_pct = 0;
		test_random_traffic(75, 1'b0, 1'b1, 0);
		test_pause_until_drained();

		wait_drain(DRAIN_CYCLES);
		$display("covered %0d words and %0d results, %0d register writes", words_sent,
			results_checked, config_writes);
		$display("all four register settings, with sender and receiver idling in turn and not at all");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/qgemm_pkg.sv
src/qgemm_cfg.sv
src/qgemm_prep.sv
src/quantized_gemm_dot_accumulate.sv
sim/quantized_gemm_dot_accumulate_tb.sv
